### hdl/bmft_pkg.sv
`default_nettype none

package bmft_pkg;

	// Fixed field widths
	localparam int SECTOR_W = 10;
	localparam int ADDR_W   = 10;
	localparam int CMD_W    = 3;

	// Default geometry
	localparam int PAGES_PER_BLK_DEF = 16;
	localparam int BLOCK_COUNT_DEF   = 64;

	// Flash command codes
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PROG     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_COPY     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REJECT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_UNMAPPED = 3'd5;

	// Request mode
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [SECTOR_W-1:0] sector;
	} req_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] target_addr;
		logic [ADDR_W-1:0] source_addr;
		logic              last;
	} rsp_t;

endpackage

`default_nettype wire

### hdl/bmft_ram.sv
`default_nettype none

module bmft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### hdl/block_mapping_flash_translation.sv
// Sequence: a reject gives its single transfer after the divide and remainder steps, a
//   read or a first write to a block after the map lookup as well, a write to a free page
//   of a mapped block after the used-page check too; an overwrite gives its copies, its
//   program and its erase. A new request is taken only in idle; the overwrite page scan
//   visits one page per cycle unless a copy stalls, adding the page to precomputed bases.
// Reset: asynchronous, active low; a clearing pass then marks every block map entry unmapped,
//   and requests are stalled until it ends.
`default_nettype none

module block_mapping_flash_translation
	import bmft_pkg::*;
#(
	parameter int PAGES_PER_BLK = PAGES_PER_BLK_DEF,
	parameter int BLOCK_COUNT   = BLOCK_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp_data
);

	localparam int BLK_W   = $clog2(BLOCK_COUNT);
	localparam int OFF_W   = $clog2(PAGES_PER_BLK);
	localparam int DIV_SH  = 16;
	localparam int RECIP   = (2**DIV_SH + PAGES_PER_BLK - 1) / PAGES_PER_BLK;
	localparam int MB_W    = 16;
	localparam int PROD_W  = SECTOR_W + MB_W;
	localparam logic [BLK_W-1:0]  LAST_BLK  = BLK_W'(BLOCK_COUNT - 1);
	localparam logic [OFF_W-1:0]  LAST_PAGE = OFF_W'(PAGES_PER_BLK - 1);
	localparam logic [SECTOR_W:0] LBN_LIMIT = (SECTOR_W+1)'(BLOCK_COUNT - 1);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_DIV   = 13'b0000000000100,
		S_REM   = 13'b0000000001000,
		S_MAP   = 13'b0000000010000,
		S_USED  = 13'b0000000100000,
		S_BASE  = 13'b0000001000000,
		S_EMIT  = 13'b0000010000000,
		S_SPB   = 13'b0000100000000,
		S_PBB   = 13'b0001000000000,
		S_COPY  = 13'b0010000000000,
		S_PROG2 = 13'b0100000000000,
		S_ERASE = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Control state
	logic [BLK_W-1:0] next_free_q;
	logic [BLK_W-1:0] spare_q;
	logic [BLK_W-1:0] clr_idx_q;

	// Request payload and working registers
	logic                     mode_q;
	logic [SECTOR_W-1:0]      sector_q;
	logic [SECTOR_W-1:0]      lbn_q;
	logic [OFF_W-1:0]         off_q;
	logic [BLK_W-1:0]         pbn_q;
	logic [CMD_W-1:0]         cmd_q;
	logic [PAGES_PER_BLK-1:0] used_q;
	logic [ADDR_W-1:0]        sbase_q;
	logic [ADDR_W-1:0]        pbase_q;
	logic [OFF_W-1:0]         page_q;

	// Output register
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic can_load;
	logic rsp_load;
	rsp_t rsp_next;

	// Shared multiplier
	logic [SECTOR_W-1:0] mul_a;
	logic [MB_W-1:0]     mul_b;
	logic [PROD_W-1:0]   prod;

	// Memories
	logic                     map_wr_en;
	logic [BLK_W-1:0]         map_wr_addr;
	logic [BLK_W:0]           map_wr_data;
	logic [BLK_W:0]           map_rd_data;
	logic                     pg_wr_en;
	logic [BLK_W-1:0]         pg_wr_addr;
	logic [PAGES_PER_BLK-1:0] pg_wr_data;
	logic [PAGES_PER_BLK-1:0] pg_rd_data;

	logic [BLK_W-1:0]         lbn_idx;
	logic                     map_unmapped;
	logic [PAGES_PER_BLK-1:0] page_bit;
	logic                     copy_hit;
	logic                     lbn_reserved;
	logic [SECTOR_W-1:0]      rem_diff;

	assign lbn_idx      = lbn_q[BLK_W-1:0];
	assign map_unmapped = map_rd_data[BLK_W];
	assign page_bit     = PAGES_PER_BLK'(1) << off_q;
	assign copy_hit     = used_q[page_q] && (page_q != off_q);
	assign lbn_reserved = {1'b0, lbn_q} >= LBN_LIMIT;
	assign rem_diff     = sector_q - prod[SECTOR_W-1:0];
	assign can_load     = !rsp_valid_q || !rsp_stall;
	assign req_stall    = (state_q != S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

	// Select multiplier operands per step
	always_comb begin
		mul_a = sector_q;
		mul_b = MB_W'(PAGES_PER_BLK);
		case (state_q)
			S_DIV: begin
				mul_a = sector_q;
				mul_b = MB_W'(RECIP);
			end
			S_REM: begin
				mul_a = lbn_q;
			end
			S_SPB: begin
				mul_a = SECTOR_W'(spare_q);
			end
			S_BASE, S_PBB: begin
				mul_a = SECTOR_W'(pbn_q);
			end
			default: begin
				mul_a = sector_q;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Block map: logical block to physical block plus unmapped flag
	always_comb begin
		map_wr_en   = 1'b0;
		map_wr_addr = lbn_idx;
		map_wr_data = {1'b0, next_free_q};
		case (state_q)
			S_CLEAR: begin
				map_wr_en   = 1'b1;
				map_wr_addr = clr_idx_q;
				map_wr_data = {1'b1, {BLK_W{1'b0}}};
			end
			S_MAP: begin
				map_wr_en = (mode_q == MODE_WRITE) && map_unmapped && (next_free_q != LAST_BLK);
			end
			S_PROG2: begin
				map_wr_en   = 1'b1;
				map_wr_data = {1'b0, spare_q};
			end
			default: begin
				map_wr_en = 1'b0;
			end
		endcase
	end

	// Used-page bitmap per physical block
	always_comb begin
		pg_wr_en   = 1'b0;
		pg_wr_addr = pbn_q;
		pg_wr_data = pg_rd_data | page_bit;
		case (state_q)
			S_MAP: begin
				pg_wr_en   = (mode_q == MODE_WRITE) && map_unmapped && (next_free_q != LAST_BLK);
				pg_wr_addr = next_free_q;
				pg_wr_data = page_bit;
			end
			S_USED: begin
				pg_wr_en = !pg_rd_data[off_q];
			end
			S_PROG2: begin
				pg_wr_en   = 1'b1;
				pg_wr_addr = spare_q;
				pg_wr_data = used_q;
			end
			S_ERASE: begin
				pg_wr_en   = 1'b1;
				pg_wr_data = '0;
			end
			default: begin
				pg_wr_en = 1'b0;
			end
		endcase
	end

	bmft_ram #(
		.WIDTH (BLK_W + 1),
		.DEPTH (BLOCK_COUNT)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data),
		.rd_addr (lbn_idx),
		.rd_data (map_rd_data)
	);

	bmft_ram #(
		.WIDTH (PAGES_PER_BLK),
		.DEPTH (BLOCK_COUNT)
	) u_page_ram (
		.clk     (clk),
		.wr_en   (pg_wr_en),
		.wr_addr (pg_wr_addr),
		.wr_data (pg_wr_data),
		.rd_addr (map_rd_data[BLK_W-1:0]),
		.rd_data (pg_rd_data)
	);

	// Build the next command transfer
	always_comb begin
		rsp_load = 1'b0;
		rsp_next = '0;
		case (state_q)
			S_EMIT: begin
				rsp_load         = can_load;
				rsp_next.command = cmd_q;
				rsp_next.last    = 1'b1;
			end
			S_BASE: begin
				rsp_load             = can_load;
				rsp_next.command     = cmd_q;
				rsp_next.target_addr = prod[ADDR_W-1:0] + ADDR_W'(off_q);
				rsp_next.last        = 1'b1;
			end
			S_COPY: begin
				rsp_load             = can_load && copy_hit;
				rsp_next.command     = CMD_COPY;
				rsp_next.target_addr = sbase_q + ADDR_W'(page_q);
				rsp_next.source_addr = pbase_q + ADDR_W'(page_q);
			end
			S_PROG2: begin
				rsp_load             = can_load;
				rsp_next.command     = CMD_PROG;
				rsp_next.target_addr = sbase_q + ADDR_W'(off_q);
			end
			S_ERASE: begin
				rsp_load             = can_load;
				rsp_next.command     = CMD_ERASE;
				rsp_next.target_addr = ADDR_W'(pbn_q);
				rsp_next.last        = 1'b1;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	// Sequencer and allocation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			next_free_q <= '0;
			spare_q     <= LAST_BLK;
			clr_idx_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Hold a stalled transfer, drop a taken one
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_BLK) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_REM;
				end
				S_REM: begin
					state_q <= lbn_reserved ? S_EMIT : S_MAP;
				end
				S_MAP: begin
					if (mode_q == MODE_READ) begin
						state_q <= map_unmapped ? S_EMIT : S_BASE;
					end else if (map_unmapped) begin
						if (next_free_q == LAST_BLK) begin
							state_q <= S_EMIT;
						end else begin
							next_free_q <= next_free_q + 1'b1;
							state_q     <= S_BASE;
						end
					end else begin
						state_q <= S_USED;
					end
				end
				S_USED: begin
					state_q <= pg_rd_data[off_q] ? S_SPB : S_BASE;
				end
				S_BASE, S_EMIT: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				S_SPB: begin
					state_q <= S_PBB;
				end
				S_PBB: begin
					state_q <= S_COPY;
				end
				S_COPY: begin
					if ((!copy_hit || can_load) && (page_q == LAST_PAGE)) begin
						state_q <= S_PROG2;
					end
				end
				S_PROG2: begin
					if (can_load) begin
						state_q <= S_ERASE;
					end
				end
				S_ERASE: begin
					if (can_load) begin
						spare_q <= pbn_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current request
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
		case (state_q)
			S_IDLE: begin
				mode_q   <= req_data.mode;
				sector_q <= req_data.sector;
			end
			S_DIV: begin
				lbn_q <= prod[DIV_SH +: SECTOR_W];
			end
			S_REM: begin
				off_q <= rem_diff[OFF_W-1:0];
				cmd_q <= CMD_REJECT;
			end
			S_MAP: begin
				if (mode_q == MODE_READ) begin
					pbn_q <= map_rd_data[BLK_W-1:0];
					cmd_q <= map_unmapped ? CMD_UNMAPPED : CMD_READ;
				end else if (map_unmapped) begin
					pbn_q <= next_free_q;
					cmd_q <= (next_free_q == LAST_BLK) ? CMD_REJECT : CMD_PROG;
				end else begin
					pbn_q <= map_rd_data[BLK_W-1:0];
					cmd_q <= CMD_PROG;
				end
			end
			S_USED: begin
				used_q <= pg_rd_data;
			end
			S_SPB: begin
				sbase_q <= prod[ADDR_W-1:0];
			end
			S_PBB: begin
				pbase_q <= prod[ADDR_W-1:0];
				page_q  <= '0;
			end
			S_COPY: begin
				if ((!copy_hit || can_load) && (page_q != LAST_PAGE)) begin
					page_q <= page_q + 1'b1;
				end
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	// An erase always closes its request
	a_erase_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.command == CMD_ERASE) |-> rsp_data.last)
		else $error("erase transfer without last");

	// A copy never closes its request
	a_copy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.command == CMD_COPY) |-> !rsp_data.last)
		else $error("copy transfer marked last");

	// The spare is the reserved block or one already handed out
	a_spare_known: assert property (@(posedge clk) disable iff (!arst_n)
		(spare_q == LAST_BLK) || (spare_q < next_free_q))
		else $error("spare block lies in the never-used range");

	// A request is only taken after the clearing pass
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ($past(state_q) == S_IDLE))
		else $error("request started outside idle");
`endif

endmodule

`default_nettype wire
